// ===== sv/ple_pkg.sv =====
// shared types and constants for the positional list engine
package ple_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned CNT_W  = 8;
    localparam int unsigned POS_W  = 8;
    localparam int unsigned MODE_W = 3;

    // request operation codes
    localparam logic [MODE_W-1:0] MODE_READ   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_MODIFY = 3'd1;
    localparam logic [MODE_W-1:0] MODE_INSERT = 3'd2;
    localparam logic [MODE_W-1:0] MODE_APPEND = 3'd3;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd4;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd5;

    // capacity after reset
    localparam logic [CNT_W-1:0] CAP_RESET = 8'd128;

endpackage

// ===== sv/ple_req_if.sv =====
// request channel: operation, position and value
interface ple_req_if
    import ple_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [MODE_W-1:0]        mode;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output mode, output position, output value, input ready);
    modport sink   (input valid, input mode, input position, input value, output ready);
endinterface

// ===== sv/ple_rsp_if.sv =====
// response channel: status, read data and list size
interface ple_rsp_if
    import ple_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic                     ok;
    logic signed [DATA_W-1:0] read_value;
    logic [CNT_W-1:0]         count;
    logic                     empty_res;
    logic                     full_res;

    modport source (output valid, output ok, output read_value, output count,
                    output empty_res, output full_res, input ready);
    modport sink   (input valid, input ok, input read_value, input count,
                    input empty_res, input full_res, output ready);
endinterface

// ===== sv/ple_ram.sv =====
// single-port-write, single-port-read entry memory with registered read data
module ple_ram
    import ple_pkg::*;
#(
    parameter int DEPTH = 128,
    parameter int AW    = 7
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [AW-1:0]     raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== sv/ple_ctrl.sv =====
// operation sequencer: decodes requests, walks shifts through the memory, holds the result
module ple_ctrl
    import ple_pkg::*;
#(
    parameter int DEPTH = 128,
    parameter int AW    = 7
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [CNT_W-1:0]  capacity,
    ple_req_if.sink           req,
    ple_rsp_if.source         rsp,
    output logic              ram_we,
    output logic [AW-1:0]     ram_waddr,
    output logic [DATA_W-1:0] ram_wdata,
    output logic              ram_re,
    output logic [AW-1:0]     ram_raddr,
    input  logic [DATA_W-1:0] ram_rdata
);

    localparam int DLIM_I = (DEPTH > 255) ? 255 : DEPTH;
    localparam logic [CNT_W-1:0] DLIM = CNT_W'(DLIM_I);

    typedef enum logic [1:0] {S_IDLE, S_SHIFT, S_PUT, S_RESULT} state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  ptr_reg, ptr_next;
    logic [CNT_W-1:0]  end_reg, end_next;
    logic [CNT_W-1:0]  wptr_reg, wptr_next;
    logic              rd_more_reg, rd_more_next;
    logic              wr_pend_reg, wr_pend_next;
    logic              first_reg, first_next;
    logic              up_reg, up_next;
    logic [DATA_W-1:0] val_reg, val_next;
    logic              res_ok_reg, res_ok_next;
    logic [DATA_W-1:0] res_rd_reg, res_rd_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_ok_reg, out_ok_next;
    logic [DATA_W-1:0] out_rd_reg, out_rd_next;
    logic [CNT_W-1:0]  out_cnt_reg, out_cnt_next;
    logic              out_empty_reg, out_empty_next;
    logic              out_full_reg, out_full_next;

    logic             accept;
    logic             is_full;
    logic             in_list;
    logic             ins_pos_ok;
    logic [CNT_W-1:0] pos_m1;
    logic             out_free;

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign out_free  = !out_valid_reg || rsp.ready;

    // request decode against the current list size
    assign pos_m1     = req.position - 8'd1;
    assign is_full    = (cnt_reg >= capacity) || (cnt_reg >= DLIM);
    assign in_list    = (req.position != 8'd0) && (req.position <= cnt_reg)
                        && (req.position <= DLIM);
    assign ins_pos_ok = (req.position != 8'd0)
                        && ({1'b0, req.position} <= ({1'b0, cnt_reg} + 9'd1));

    // memory port drive
    always_comb
    begin
        ram_re    = 1'b0;
        ram_raddr = AW'(ptr_reg);
        ram_we    = 1'b0;
        ram_waddr = AW'(wptr_reg);
        ram_wdata = ram_rdata;
        unique case (state_reg)
            S_SHIFT:
            begin
                ram_re = rd_more_reg;
                ram_we = wr_pend_reg && !first_reg;
            end
            S_PUT:
            begin
                ram_we    = 1'b1;
                ram_wdata = val_reg;
            end
            S_IDLE, S_RESULT:
            begin
                ram_re = 1'b0;
            end
        endcase
    end

    // sequencing
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        ptr_next       = ptr_reg;
        end_next       = end_reg;
        wptr_next      = wptr_reg;
        rd_more_next   = rd_more_reg;
        wr_pend_next   = wr_pend_reg;
        first_next     = first_reg;
        up_next        = up_reg;
        val_next       = val_reg;
        res_ok_next    = res_ok_reg;
        res_rd_next    = res_rd_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_ok_next    = out_ok_reg;
        out_rd_next    = out_rd_reg;
        out_cnt_next   = out_cnt_reg;
        out_empty_next = out_empty_reg;
        out_full_next  = out_full_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    val_next     = req.value;
                    res_ok_next  = 1'b0;
                    res_rd_next  = '0;
                    wr_pend_next = 1'b0;
                    rd_more_next = 1'b1;
                    first_next   = 1'b0;
                    up_next      = 1'b0;
                    state_next   = S_RESULT;
                    unique case (req.mode)
                        MODE_READ:
                        begin
                            if (in_list)
                            begin
                                res_ok_next = 1'b1;
                                ptr_next    = pos_m1;
                                end_next    = pos_m1;
                                first_next  = 1'b1;
                                state_next  = S_SHIFT;
                            end
                        end
                        MODE_MODIFY:
                        begin
                            if (in_list)
                            begin
                                res_ok_next = 1'b1;
                                wptr_next   = pos_m1;
                                state_next  = S_PUT;
                            end
                        end
                        MODE_INSERT:
                        begin
                            if (!is_full && ins_pos_ok)
                            begin
                                res_ok_next = 1'b1;
                                cnt_next    = cnt_reg + 8'd1;
                                if (pos_m1 == cnt_reg)
                                begin
                                    wptr_next  = pos_m1;
                                    state_next = S_PUT;
                                end
                                else
                                begin
                                    ptr_next   = cnt_reg - 8'd1;
                                    end_next   = pos_m1;
                                    up_next    = 1'b1;
                                    state_next = S_SHIFT;
                                end
                            end
                        end
                        MODE_APPEND:
                        begin
                            if (!is_full)
                            begin
                                res_ok_next = 1'b1;
                                cnt_next    = cnt_reg + 8'd1;
                                wptr_next   = cnt_reg;
                                state_next  = S_PUT;
                            end
                        end
                        MODE_REMOVE:
                        begin
                            if (in_list)
                            begin
                                res_ok_next = 1'b1;
                                cnt_next    = cnt_reg - 8'd1;
                                ptr_next    = pos_m1;
                                end_next    = cnt_reg - 8'd1;
                                first_next  = 1'b1;
                                state_next  = S_SHIFT;
                            end
                        end
                        MODE_CLEAR:
                        begin
                            res_ok_next = 1'b1;
                            cnt_next    = '0;
                        end
                        default:
                        begin
                            res_ok_next = 1'b0;
                        end
                    endcase
                end
            end

            // one read per cycle; data written back next cycle unless kept as result
            S_SHIFT:
            begin
                if (wr_pend_reg && first_reg)
                begin
                    res_rd_next = ram_rdata;
                end
                if (wr_pend_reg)
                begin
                    first_next = 1'b0;
                end
                if (rd_more_reg)
                begin
                    wptr_next    = up_reg ? (ptr_reg + 8'd1) : (ptr_reg - 8'd1);
                    wr_pend_next = 1'b1;
                    if (ptr_reg == end_reg)
                    begin
                        rd_more_next = 1'b0;
                    end
                    else
                    begin
                        ptr_next = up_reg ? (ptr_reg - 8'd1) : (ptr_reg + 8'd1);
                    end
                end
                else
                begin
                    wr_pend_next = 1'b0;
                    if (up_reg)
                    begin
                        wptr_next  = end_reg;
                        state_next = S_PUT;
                    end
                    else
                    begin
                        state_next = S_RESULT;
                    end
                end
            end

            S_PUT:
            begin
                state_next = S_RESULT;
            end

            // hand the result to the output register once it is free
            S_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_ok_next    = res_ok_reg;
                    out_rd_next    = res_rd_reg;
                    out_cnt_next   = cnt_reg;
                    out_empty_next = (cnt_reg == '0);
                    out_full_next  = (cnt_reg >= capacity) || (cnt_reg >= DLIM);
                    state_next     = S_IDLE;
                end
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            rd_more_reg   <= 1'b0;
            wr_pend_reg   <= 1'b0;
            first_reg     <= 1'b0;
            up_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rd_more_reg   <= rd_more_next;
            wr_pend_reg   <= wr_pend_next;
            first_reg     <= first_next;
            up_reg        <= up_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        ptr_reg       <= ptr_next;
        end_reg       <= end_next;
        wptr_reg      <= wptr_next;
        val_reg       <= val_next;
        res_ok_reg    <= res_ok_next;
        res_rd_reg    <= res_rd_next;
        out_ok_reg    <= out_ok_next;
        out_rd_reg    <= out_rd_next;
        out_cnt_reg   <= out_cnt_next;
        out_empty_reg <= out_empty_next;
        out_full_reg  <= out_full_next;
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.ok         = out_ok_reg;
    assign rsp.read_value = out_rd_reg;
    assign rsp.count      = out_cnt_reg;
    assign rsp.empty_res  = out_empty_reg;
    assign rsp.full_res   = out_full_reg;

endmodule

// ===== sv/positional_list_engine.sv =====
// positional list engine top level: capacity register, sequencer and entry memory
//
//   channel  direction  payload                                    handshake
//   req      in         mode, position, value                      valid/ready
//   rsp      out        ok, read_value, count, empty_res, full_res valid/ready
//   cfg      in         cfg_wr_data (capacity)                     cfg_wr_en
//
// one request at a time; the entry memory has one write and one read port.
// insert and remove shift every entry between the position and the end of the
// list by one place; a shift moves one entry per cycle through the memory.
// read and modify touch one entry, append writes one, clear resets the size.
// reset clears the size and sets capacity to 128; the memory is not cleared.
// a waiting response does not block the next request, which finishes and then
// waits until the output register is free.
module positional_list_engine
    import ple_pkg::*;
#(
    parameter int DEPTH = 128
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [CNT_W-1:0] cfg_wr_data,
    ple_req_if.sink          req,
    ple_rsp_if.source        rsp
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [CNT_W-1:0]  capacity_reg;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [DATA_W-1:0] ram_rdata;

    // capacity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
        end
        else if (cfg_wr_en)
        begin
            capacity_reg <= cfg_wr_data;
        end
    end

    ple_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .capacity  (capacity_reg),
        .req       (req),
        .rsp       (rsp),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    ple_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule
